// ===== hdl/cmfuv_pkg.sv =====
// ----------------------------------------------------------------------------
// cmfuv_pkg
// Types, face codes and per-face axis tables for cube map face selection.
// ----------------------------------------------------------------------------
package cmfuv_pkg;

  localparam int DIR_W           = 16;
  localparam int MAG_W           = 16;  // |-32768| still fits unsigned
  localparam int REM_W           = MAG_W + 1;
  localparam int FACE_W          = 3;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 14;

  typedef logic signed [DIR_W-1:0] dir_t;
  typedef logic        [MAG_W-1:0] mag_t;

  typedef enum logic [FACE_W-1:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // one word after input capture: raw components and their magnitudes
  typedef struct packed {
    dir_t x;
    dir_t y;
    dir_t z;
    mag_t ax;
    mag_t ay;
    mag_t az;
  } cap_t;

  // one word after face selection
  typedef struct packed {
    face_t face;
    mag_t  r_mag;
    mag_t  u_mag;
    mag_t  f_mag;
    logic  r_neg;
    logic  u_neg;
    logic  nz;
  } sel_t;

  function automatic mag_t mag_of(input dir_t v);
    mag_t raw;
    raw = mag_t'(v);
    return v[DIR_W-1] ? (~raw + mag_t'(1)) : raw;
  endfunction

  // right axis per face: -z, z, x, -x, x, -x
  function automatic axis_t right_axis(input face_t f);
    axis_t a;
    unique case (f)
      FACE_PX, FACE_NX: a = AXIS_Z;
      default:          a = AXIS_X;
    endcase
    return a;
  endfunction

  function automatic logic right_flip(input face_t f);
    logic n;
    unique case (f)
      FACE_PX, FACE_NY, FACE_NZ: n = 1'b1;
      default:                   n = 1'b0;
    endcase
    return n;
  endfunction

  // up axis per face: y, y, z, -z, y, y
  function automatic axis_t up_axis(input face_t f);
    axis_t a;
    unique case (f)
      FACE_PY, FACE_NY: a = AXIS_Z;
      default:          a = AXIS_Y;
    endcase
    return a;
  endfunction

  function automatic logic up_flip(input face_t f);
    return (f == FACE_NY);
  endfunction

  function automatic mag_t pick_mag(input axis_t a, input cap_t c);
    mag_t m;
    unique case (a)
      AXIS_X:  m = c.ax;
      AXIS_Y:  m = c.ay;
      default: m = c.az;
    endcase
    return m;
  endfunction

  function automatic logic pick_sign(input axis_t a, input cap_t c);
    logic s;
    unique case (a)
      AXIS_X:  s = c.x[DIR_W-1];
      AXIS_Y:  s = c.y[DIR_W-1];
      default: s = c.z[DIR_W-1];
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/cube_map_face_uv.sv =====
// ----------------------------------------------------------------------------
// cube_map_face_uv
// Cube map face selection with face-local u/v coordinates in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  in_valid / in_stall with in_dir_x, in_dir_y, in_dir_z.
//   Output channel out_valid / out_stall with out_face_index, out_coord_u,
//   out_coord_v, out_result_valid. A word moves when valid is high and stall
//   is low.
//   Throughput: one word per cycle while out_stall is low. The pipeline
//   is FRAC_BITS+4 register stages: capture/abs, face select, FRAC_BITS+1
//   restoring-division stages (one quotient bit per stage, u and v in
//   parallel), and the sign/saturate output register.
//   Each stage holds its own valid bit; a stage loads when it is empty or
//   its word moves on, so bubbles collapse and input keeps flowing while the
//   output is stalled until the pipeline is full. A stalled output word holds.
//   Reset (rst_n low, synchronous) clears all valid bits; the block accepts
//   a word in the first cycle after reset.
//   An all-zero vector gives face 0, u = v = 0 and out_result_valid = 0.
// ----------------------------------------------------------------------------
module cube_map_face_uv
  import cmfuv_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [DIR_W-1:0]       in_dir_x,
  input  logic signed [DIR_W-1:0]       in_dir_y,
  input  logic signed [DIR_W-1:0]       in_dir_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic        [FACE_W-1:0]      out_face_index,
  output logic signed [COORD_WIDTH-1:0] out_coord_u,
  output logic signed [COORD_WIDTH-1:0] out_coord_v,
  output logic                          out_result_valid
);

  localparam int QW = FRAC_BITS + 1;          // quotient magnitude <= 2^FRAC_BITS
  localparam int L  = FRAC_BITS + 4;          // total stages
  localparam int EW = ((QW > COORD_WIDTH) ? QW : COORD_WIDTH) + 1;

  function automatic logic [COORD_WIDTH-1:0] to_coord(input logic [QW-1:0] q,
                                                      input logic neg);
    logic [EW-1:0] qe;
    logic [EW-1:0] lim_pos;
    logic [EW-1:0] lim_neg;
    logic [EW-1:0] negq;
    qe      = EW'(q);
    lim_neg = EW'(1) << (COORD_WIDTH - 1);
    lim_pos = lim_neg - EW'(1);
    negq    = ~qe + EW'(1);
    if (neg) begin
      if (qe > lim_neg) return lim_neg[COORD_WIDTH-1:0];
      else return negq[COORD_WIDTH-1:0];
    end else begin
      if (qe > lim_pos) return lim_pos[COORD_WIDTH-1:0];
      else return qe[COORD_WIDTH-1:0];
    end
  endfunction

  logic [L-1:0] vld_r;
  logic [L-1:0] ld;

  // stage 0: capture and magnitudes
  cap_t cap_r;
  cap_t cap_nxt;
  // stage 1: face and component selection
  sel_t sel_r;
  sel_t sel_nxt;
  // division stages
  logic [REM_W-1:0] rdiv_rem_r [QW];
  logic [REM_W-1:0] udiv_rem_r [QW];
  logic [QW-1:0]    rdiv_q_r   [QW];
  logic [QW-1:0]    udiv_q_r   [QW];
  mag_t             div_den_r  [QW];
  face_t            div_face_r [QW];
  logic             div_rneg_r [QW];
  logic             div_uneg_r [QW];
  logic             div_nz_r   [QW];
  // output stage
  logic [FACE_W-1:0]      face_out_r;
  logic [COORD_WIDTH-1:0] u_out_r;
  logic [COORD_WIDTH-1:0] v_out_r;
  logic                   rv_out_r;
  logic [COORD_WIDTH-1:0] u_out_nxt;
  logic [COORD_WIDTH-1:0] v_out_nxt;

  // a stage loads when empty or when its word moves on
  always_comb begin
    ld[L-1] = !vld_r[L-1] || !out_stall;
    for (int k = L - 2; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  assign in_stall = !ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < L; k++) begin
        if (ld[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // stage 0
  always_comb begin
    cap_nxt.x  = in_dir_x;
    cap_nxt.y  = in_dir_y;
    cap_nxt.z  = in_dir_z;
    cap_nxt.ax = mag_of(in_dir_x);
    cap_nxt.ay = mag_of(in_dir_y);
    cap_nxt.az = mag_of(in_dir_z);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) cap_r <= cap_nxt;
  end

  // stage 1: ties go X, then Y, then Z
  always_comb begin
    axis_t ra;
    axis_t ua;
    priority if (cap_r.ax >= cap_r.ay && cap_r.ax >= cap_r.az) begin
      sel_nxt.face  = cap_r.x[DIR_W-1] ? FACE_NX : FACE_PX;
      sel_nxt.f_mag = cap_r.ax;
    end else if (cap_r.ay >= cap_r.az) begin
      sel_nxt.face  = cap_r.y[DIR_W-1] ? FACE_NY : FACE_PY;
      sel_nxt.f_mag = cap_r.ay;
    end else begin
      sel_nxt.face  = cap_r.z[DIR_W-1] ? FACE_NZ : FACE_PZ;
      sel_nxt.f_mag = cap_r.az;
    end
    ra = right_axis(sel_nxt.face);
    ua = up_axis(sel_nxt.face);
    sel_nxt.r_mag = pick_mag(ra, cap_r);
    sel_nxt.u_mag = pick_mag(ua, cap_r);
    // sign only matters when the magnitude is nonzero
    sel_nxt.r_neg = pick_sign(ra, cap_r) ^ right_flip(sel_nxt.face);
    sel_nxt.u_neg = pick_sign(ua, cap_r) ^ up_flip(sel_nxt.face);
    sel_nxt.nz    = (sel_nxt.f_mag != '0);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) sel_r <= sel_nxt;
  end

  // restoring division, MSB first; first step has weight 2^FRAC_BITS
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [REM_W-1:0] r_src;
    logic [REM_W-1:0] u_src;
    logic [QW-1:0]    rq_src;
    logic [QW-1:0]    uq_src;
    mag_t             den_src;
    face_t            face_src;
    logic             rneg_src;
    logic             uneg_src;
    logic             nz_src;
    logic [REM_W-1:0] r_trial;
    logic [REM_W-1:0] u_trial;
    logic [REM_W-1:0] den_e;
    logic             r_bit;
    logic             u_bit;
    logic [REM_W-1:0] rrem_nxt;
    logic [REM_W-1:0] urem_nxt;
    logic [QW-1:0]    rq_nxt;
    logic [QW-1:0]    uq_nxt;

    if (k == 0) begin : g_first
      assign r_src    = {1'b0, sel_r.r_mag};
      assign u_src    = {1'b0, sel_r.u_mag};
      assign rq_src   = '0;
      assign uq_src   = '0;
      assign den_src  = sel_r.f_mag;
      assign face_src = sel_r.face;
      assign rneg_src = sel_r.r_neg;
      assign uneg_src = sel_r.u_neg;
      assign nz_src   = sel_r.nz;
      assign r_trial  = r_src;
      assign u_trial  = u_src;
    end else begin : g_next
      assign r_src    = rdiv_rem_r[k-1];
      assign u_src    = udiv_rem_r[k-1];
      assign rq_src   = rdiv_q_r[k-1];
      assign uq_src   = udiv_q_r[k-1];
      assign den_src  = div_den_r[k-1];
      assign face_src = div_face_r[k-1];
      assign rneg_src = div_rneg_r[k-1];
      assign uneg_src = div_uneg_r[k-1];
      assign nz_src   = div_nz_r[k-1];
      // remainder stays below the divisor, so the shift cannot overflow
      assign r_trial  = {r_src[REM_W-2:0], 1'b0};
      assign u_trial  = {u_src[REM_W-2:0], 1'b0};
    end

    always_comb begin
      den_e    = {1'b0, den_src};
      r_bit    = (r_trial >= den_e);
      u_bit    = (u_trial >= den_e);
      rrem_nxt = r_bit ? (r_trial - den_e) : r_trial;
      urem_nxt = u_bit ? (u_trial - den_e) : u_trial;
      rq_nxt   = {rq_src[QW-2:0], r_bit};
      uq_nxt   = {uq_src[QW-2:0], u_bit};
    end

    always_ff @(posedge clk) begin
      if (ld[k+2]) begin
        rdiv_rem_r[k] <= rrem_nxt;
        udiv_rem_r[k] <= urem_nxt;
        rdiv_q_r[k]   <= rq_nxt;
        udiv_q_r[k]   <= uq_nxt;
        div_den_r[k]  <= den_src;
        div_face_r[k] <= face_src;
        div_rneg_r[k] <= rneg_src;
        div_uneg_r[k] <= uneg_src;
        div_nz_r[k]   <= nz_src;
      end
    end
  end

  // output stage: apply sign, saturate, squash the zero vector
  always_comb begin
    if (div_nz_r[QW-1]) begin
      u_out_nxt = to_coord(rdiv_q_r[QW-1], div_rneg_r[QW-1]);
      v_out_nxt = to_coord(udiv_q_r[QW-1], div_uneg_r[QW-1]);
    end else begin
      u_out_nxt = '0;
      v_out_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[L-1]) begin
      face_out_r <= FACE_W'(div_face_r[QW-1]);
      u_out_r    <= u_out_nxt;
      v_out_r    <= v_out_nxt;
      rv_out_r   <= div_nz_r[QW-1];
    end
  end

  assign out_valid        = vld_r[L-1];
  assign out_face_index   = face_out_r;
  assign out_coord_u      = u_out_r;
  assign out_coord_v      = v_out_r;
  assign out_result_valid = rv_out_r;

endmodule
